[sv/swft_pkg.sv]
// Shared types and constants for the single-wire frame transceiver.
`default_nettype none
package swft_pkg;

  // Number of data bits in one frame
  localparam int unsigned DATA_BITS = 32;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned SHIFT_W   = 5;

  // Spare slot of the frame; the slot after it closes the frame
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(2 + DATA_BITS);

  // Slot codes with a fixed meaning
  localparam logic [SLOT_W-1:0] SLOT_START_ACTIVE = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] SLOT_START_IDLE   = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_FIRST_DATA   = SLOT_W'(2);

  // Input command codes
  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_SEND = 1'b1
  } swft_cmd_t;

  // Engine state
  typedef struct packed {
    logic              phase_even;
    logic [SLOT_W-1:0] slot_index;
    logic              sending;
    logic [WORD_W-1:0] frame_word;
    logic              drive_enable;
    logic              drive_level;
  } swft_state_t;

  // One result word
  typedef struct packed {
    logic              line_drive;
    logic              line_level;
    logic              rx_valid;
    logic [WORD_W-1:0] rx_data;
    logic              tx_busy;
  } swft_result_t;

endpackage
`default_nettype wire

[sv/swft_if.sv]
// Valid/ready channel interfaces for the transceiver's input and result words.
`default_nettype none
interface swft_in_if;
  import swft_pkg::*;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic              line_active;
  logic [WORD_W-1:0] tx_data;

  modport source (output valid, output cmd, output line_active, output tx_data,
                  input ready);
  modport sink   (input valid, input cmd, input line_active, input tx_data,
                  output ready);
endinterface

interface swft_out_if;
  import swft_pkg::*;
  logic              valid;
  logic              ready;
  logic              line_drive;
  logic              line_level;
  logic              rx_valid;
  logic [WORD_W-1:0] rx_data;
  logic              tx_busy;

  modport source (output valid, output line_drive, output line_level,
                  output rx_valid, output rx_data, output tx_busy, input ready);
  modport sink   (input valid, input line_drive, input line_level,
                  input rx_valid, input rx_data, input tx_busy, output ready);
endinterface
`default_nettype wire

[sv/single_wire_frame_transceiver_core.sv]
// Top level of the single-wire frame transceiver core.
// Usage:
//   in_ch carries one word per sample tick (cmd = 0, with line_active) or per
//   send request (cmd = 1, with tx_data). Data slots advance on every other tick.
//   out_ch returns exactly one result word per accepted input word: the line
//   drive enable and level, a received frame with rx_valid, and tx_busy.
// Timing and throughput:
//   A result appears in the cycle after its input word is accepted. One input
//   word is taken every cycle while out_ch takes each result; the slot state
//   update is a single pass of logic between the state and result registers.
// Reset:
//   rst (synchronous) puts the engine at slot 0, even phase, not sending,
//   line released, and empties the result register.
// Stalls:
//   When out_ch is not taken, the result holds in its register; one more
//   input word is accepted only if that register drains in the same cycle.
`default_nettype none
module single_wire_frame_transceiver_core (
  input  logic        clk,
  input  logic        rst,
  swft_in_if.sink     in_ch,
  swft_out_if.source  out_ch
);
  import swft_pkg::*;

  swft_state_t  state;
  swft_state_t  state_next;
  swft_result_t res_next;
  swft_result_t res;
  logic         out_valid;
  logic         in_fire;
  logic         out_fire;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid && out_ch.ready;

  swft_step u_step (
    .cur         (state),
    .cmd         (in_ch.cmd),
    .line_active (in_ch.line_active),
    .tx_data     (in_ch.tx_data),
    .nxt         (state_next),
    .res         (res_next)
  );

  // Engine state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase_even   <= 1'b1;
      state.slot_index   <= '0;
      state.sending      <= 1'b0;
      state.frame_word   <= '0;
      state.drive_enable <= 1'b0;
      state.drive_level  <= 1'b0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) res <= res_next;
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.line_drive = res.line_drive;
  assign out_ch.line_level = res.line_level;
  assign out_ch.rx_valid   = res.rx_valid;
  assign out_ch.rx_data    = res.rx_data;
  assign out_ch.tx_busy    = res.tx_busy;

  // A frame is only reported while the line is released
  assert property (@(posedge clk) disable iff (rst)
    out_valid && res.rx_valid |-> !res.line_drive)
    else $error("frame reported while driving the line");

  // Slot counter never passes the frame-closing slot
  assert property (@(posedge clk) disable iff (rst)
    state.slot_index <= LAST_SLOT + SLOT_W'(1))
    else $error("slot index out of range");

  // A send request at slot 0 always starts a transmission
  assert property (@(posedge clk) disable iff (rst)
    in_fire && in_ch.cmd == CMD_SEND && state.slot_index == SLOT_START_ACTIVE
      |=> state.sending && res.tx_busy)
    else $error("send request at slot 0 not taken");

  // Received data is zero outside a frame report
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !res.rx_valid |-> res.rx_data == '0)
    else $error("rx_data set without rx_valid");

endmodule
`default_nettype wire

[sv/swft_step.sv]
// Slot state machine update for one input word, and the result it produces.
`default_nettype none
module swft_step (
  input  swft_pkg::swft_state_t  cur,
  input  logic                   cmd,
  input  logic                   line_active,
  input  logic [31:0]            tx_data,
  output swft_pkg::swft_state_t  nxt,
  output swft_pkg::swft_result_t res
);
  import swft_pkg::*;

  logic [SLOT_W-1:0]  slot_off;
  logic [SHIFT_W-1:0] bit_sel;
  logic               flip;
  logic               valid;

  // Data bit position of the current slot
  assign slot_off = cur.slot_index - SLOT_FIRST_DATA;
  assign bit_sel  = slot_off[SHIFT_W-1:0];

  always_comb begin
    nxt   = cur;
    flip  = 1'b1;
    valid = 1'b0;
    if (cmd == CMD_SEND) begin
      // Send request: only taken at slot 0, phase does not move
      flip = 1'b0;
      if (cur.slot_index == SLOT_START_ACTIVE) begin
        nxt.sending    = 1'b1;
        nxt.frame_word = tx_data;
      end
    end else begin
      if (cur.phase_even) begin
        if (cur.sending) begin
          // Transmit slots
          if (cur.slot_index == SLOT_START_ACTIVE) begin
            nxt.drive_enable = 1'b0;
            if (line_active) nxt.slot_index = SLOT_START_IDLE;
          end else if (cur.slot_index == SLOT_START_IDLE) begin
            nxt.drive_enable = 1'b1;
            nxt.drive_level  = 1'b1;
            nxt.slot_index   = SLOT_FIRST_DATA;
          end else if (cur.slot_index < LAST_SLOT) begin
            nxt.drive_enable = 1'b1;
            nxt.drive_level  = ~cur.frame_word[bit_sel];
            nxt.slot_index   = cur.slot_index + SLOT_W'(1);
          end else if (cur.slot_index == LAST_SLOT) begin
            nxt.slot_index = cur.slot_index + SLOT_W'(1);
          end else begin
            nxt.sending    = 1'b0;
            nxt.slot_index = SLOT_START_ACTIVE;
          end
        end else begin
          // Receive slots
          if (cur.slot_index == SLOT_START_ACTIVE) begin
            nxt.drive_enable = 1'b0;
            if (line_active) nxt.slot_index = SLOT_START_IDLE;
          end else if (cur.slot_index == SLOT_START_IDLE) begin
            nxt.drive_enable = 1'b0;
            if (!line_active) begin
              nxt.slot_index = SLOT_FIRST_DATA;
              nxt.frame_word = '0;
            end
          end else if (cur.slot_index < LAST_SLOT) begin
            nxt.drive_enable          = 1'b0;
            nxt.frame_word[bit_sel]   = cur.frame_word[bit_sel] | line_active;
            nxt.slot_index            = cur.slot_index + SLOT_W'(1);
          end else if (cur.slot_index == LAST_SLOT) begin
            nxt.slot_index = cur.slot_index + SLOT_W'(1);
          end else begin
            nxt.slot_index = SLOT_START_ACTIVE;
            valid          = 1'b1;
          end
        end
      end else if (!cur.sending) begin
        // Odd phase while not sending: hunt for the start pattern, resync on the idle slot
        if (cur.slot_index == SLOT_START_ACTIVE) begin
          nxt.drive_enable = 1'b0;
          if (line_active) nxt.slot_index = SLOT_START_IDLE;
        end else if (cur.slot_index == SLOT_START_IDLE) begin
          nxt.drive_enable = 1'b0;
          if (!line_active) begin
            nxt.slot_index = SLOT_FIRST_DATA;
            nxt.frame_word = '0;
            flip           = 1'b0;
          end
        end
      end
    end
    if (flip) nxt.phase_even = ~cur.phase_even;
  end

  // Result word reflects the state after this update
  always_comb begin
    res.line_drive = nxt.drive_enable;
    res.line_level = nxt.drive_enable & nxt.drive_level;
    res.rx_valid   = valid;
    res.rx_data    = valid ? nxt.frame_word : '0;
    res.tx_busy    = nxt.sending;
  end

endmodule
`default_nettype wire
